[hdl/spibe_pkg.sv]
// ---------------------------------------------------------------------------
// spibe_pkg
// Shared types, register indexes and helpers for the SPI slave bit engine.
// ---------------------------------------------------------------------------
package spibe_pkg;

  localparam int unsigned BYTE_BITS = 8;

  // Position counter covers 1..BYTE_BITS plus the overflow value.
  localparam int unsigned POS_W = 4;
  localparam int unsigned CNT_W = 4;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_EDGE_FALLING = 2'd0,
    REG_DELAYED_START     = 2'd1,
    REG_LOW_BIT_FIRST     = 2'd2
  } cfg_reg_t;

  // One poll of the pins.
  typedef struct packed {
    logic                 select_n;
    logic                 clock_level;
    logic                 data_in_level;
    logic                 tick;
    logic [BYTE_BITS-1:0] send_byte;
  } item_t;

  typedef struct packed {
    logic drive_valid;
    logic drive_level;
    logic bit_valid;
    logic bit_value;
    logic separator;
    logic byte_done;
  } result_t;

  // Settings plus a one-cycle pulse when delayed start is rewritten.
  typedef struct packed {
    logic lead_edge_falling;
    logic delayed_start;
    logic low_bit_first;
    logic rearm;
  } cfg_t;

  // Bit k of the byte, counting from the MSB (k = 0).
  function automatic logic msb_bit(input logic [BYTE_BITS-1:0] b,
                                   input logic [2:0] k);
    logic [2:0] sh;
    sh = 3'(BYTE_BITS - 1) - k;
    return b[sh];
  endfunction

endpackage

[hdl/spibe_cfg.sv]
// ---------------------------------------------------------------------------
// spibe_cfg
// Configuration register file with a write channel; flags delayed-start writes.
// ---------------------------------------------------------------------------
module spibe_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spibe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                            cfg_data,
  output spibe_pkg::cfg_t                 cfg
);

  logic lead_edge_falling;
  logic delayed_start;
  logic low_bit_first;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_edge_falling <= 1'b0;
      delayed_start     <= 1'b0;
      low_bit_first     <= 1'b0;
    end else if (wr) begin
      unique case (spibe_pkg::cfg_reg_t'(cfg_index))
        spibe_pkg::REG_LEAD_EDGE_FALLING: lead_edge_falling <= cfg_data;
        spibe_pkg::REG_DELAYED_START:     delayed_start     <= cfg_data;
        spibe_pkg::REG_LOW_BIT_FIRST:     low_bit_first     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.lead_edge_falling = lead_edge_falling;
    cfg.delayed_start     = delayed_start;
    cfg.low_bit_first     = low_bit_first;
    cfg.rearm             = wr &&
      (spibe_pkg::cfg_reg_t'(cfg_index) == spibe_pkg::REG_DELAYED_START);
  end

endmodule

[hdl/spibe_core.sv]
// ---------------------------------------------------------------------------
// spibe_core
// Edge detect, bit select and counters; state advances once per processed poll.
// ---------------------------------------------------------------------------
module spibe_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  spibe_pkg::item_t  item,
  input  spibe_pkg::cfg_t   cfg,
  output spibe_pkg::result_t res
);

  localparam logic [spibe_pkg::POS_W-1:0] POS_MAX   = spibe_pkg::POS_W'(spibe_pkg::BYTE_BITS);
  localparam logic [spibe_pkg::CNT_W-1:0] CNT_MAX   = spibe_pkg::CNT_W'(spibe_pkg::BYTE_BITS);
  localparam logic [spibe_pkg::POS_W-1:0] POS_RESET = spibe_pkg::POS_W'(1);
  localparam logic [spibe_pkg::POS_W-1:0] LSB_START = spibe_pkg::POS_W'(spibe_pkg::BYTE_BITS - 1);

  logic                          last_clock, last_clock_next;
  logic                          start_wait_over, start_wait_over_next;
  logic                          first_bit_out, first_bit_out_next;
  logic                          later_bits_active, later_bits_active_next;
  logic [spibe_pkg::POS_W-1:0]   bit_position, bit_position_next;
  logic [spibe_pkg::CNT_W-1:0]   receive_count, receive_count_next;

  logic                          run;
  logic                          tick_eff;
  logic                          rising, falling, lead, trail;
  logic [spibe_pkg::POS_W-1:0]   first;
  logic [spibe_pkg::POS_W-1:0]   idx;
  logic [spibe_pkg::POS_W-1:0]   pos_inc;

  always_comb begin
    last_clock_next        = last_clock;
    start_wait_over_next   = start_wait_over;
    first_bit_out_next     = first_bit_out;
    later_bits_active_next = later_bits_active;
    bit_position_next      = bit_position;
    receive_count_next     = receive_count;
    res      = '0;
    run      = !item.select_n;
    tick_eff = item.tick;

    rising  = item.clock_level && !last_clock;
    falling = !item.clock_level && last_clock;
    lead    = cfg.lead_edge_falling ? falling : rising;
    trail   = cfg.lead_edge_falling ? rising : falling;
    first   = cfg.low_bit_first ? LSB_START : '0;
    idx     = (bit_position >= first) ? bit_position - first : first - bit_position;
    pos_inc = bit_position + 1'b1;

    // Delayed start: the ending tick is consumed by the wait.
    if (run && cfg.delayed_start && !start_wait_over) begin
      if (item.tick) begin
        start_wait_over_next = 1'b1;
        tick_eff             = 1'b0;
      end else begin
        run = 1'b0;
      end
    end

    if (run) begin
      last_clock_next = item.clock_level;

      if (lead) begin
        if (!first_bit_out) begin
          first_bit_out_next = 1'b1;
          res.drive_valid    = 1'b1;
          res.drive_level    = spibe_pkg::msb_bit(item.send_byte, first[2:0]);
        end
        res.bit_valid = 1'b1;
        res.bit_value = item.data_in_level;
      end

      if (trail && first_bit_out_next) begin
        later_bits_active_next = 1'b1;
        // index equal to the byte width leaves the line alone
        if (idx < POS_MAX) begin
          res.drive_valid = 1'b1;
          res.drive_level = spibe_pkg::msb_bit(item.send_byte, idx[2:0]);
        end
      end

      if (tick_eff) begin
        receive_count_next = receive_count + 1'b1;
        if (later_bits_active_next) begin
          bit_position_next = pos_inc;
          if (pos_inc > POS_MAX) begin
            bit_position_next      = POS_RESET;
            first_bit_out_next     = 1'b0;
            later_bits_active_next = 1'b0;
            res.byte_done          = 1'b1;
          end
        end
      end

      if (receive_count_next >= CNT_MAX) begin
        receive_count_next = '0;
        res.separator      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clock        <= 1'b0;
      start_wait_over   <= 1'b0;
      first_bit_out     <= 1'b0;
      later_bits_active <= 1'b0;
      bit_position      <= POS_RESET;
      receive_count     <= '0;
    end else begin
      if (en) begin
        last_clock        <= last_clock_next;
        start_wait_over   <= start_wait_over_next;
        first_bit_out     <= first_bit_out_next;
        later_bits_active <= later_bits_active_next;
        bit_position      <= bit_position_next;
        receive_count     <= receive_count_next;
      end
      if (cfg.rearm) begin
        start_wait_over <= 1'b0;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position >= POS_RESET && bit_position <= POS_MAX)
    else $error("bit_position out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    receive_count < CNT_MAX)
    else $error("receive_count not below byte width");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    en && res.byte_done |=> !first_bit_out && !later_bits_active &&
                            bit_position == POS_RESET)
    else $error("byte_done without clearing bit state");

  a_sep_clears: assert property (@(posedge clk) disable iff (rst)
    en && res.separator |=> receive_count == '0)
    else $error("separator without clearing receive count");

endmodule

[hdl/spi_slave_bit_engine.sv]
// ---------------------------------------------------------------------------
// spi_slave_bit_engine
// SPI slave bit engine: one pin poll in, one result beat out.
// ---------------------------------------------------------------------------
// Each accepted poll beat is held in the input register, then processed into the
// result register. Throughput: 1 beat per cycle while m_tready is held high.
// Input and result registers part the two sides; while a result waits, one more
// poll beat is taken into the empty input register, then s_tready drops.
// Reset (rst, synchronous, active high) clears settings, pin/count state and
// both valid flags; no clearing pass is needed.
module spi_slave_bit_engine (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [0] select_n, [1] clock_level, [2] data_in_level, [3] tick,
  // [11:4] send_byte, [15:12] zero
  input  logic [spibe_pkg::IN_TDATA_W-1:0]  s_tdata,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] drive_valid, [1] drive_level, [2] bit_valid, [3] bit_value,
  // [4] separator, [5] byte_done, [7:6] zero
  output logic [spibe_pkg::OUT_TDATA_W-1:0] m_tdata,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spibe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                              cfg_data
);

  spibe_pkg::cfg_t    cfg;
  spibe_pkg::item_t   poll;         // input register payload
  logic               poll_valid;
  spibe_pkg::result_t res;
  spibe_pkg::result_t out_res;      // result register payload
  logic               out_valid;
  logic               out_free;
  logic               process;
  logic               in_beat;

  // Result slot frees when empty or being taken this cycle.
  assign out_free = !out_valid || m_tready;
  assign process  = poll_valid && out_free;
  assign s_tready = !poll_valid || process;
  assign in_beat  = s_tvalid && s_tready;

  spibe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_beat) begin
      poll_valid <= 1'b1;
    end else if (process) begin
      poll_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      poll.select_n      <= s_tdata[0];
      poll.clock_level   <= s_tdata[1];
      poll.data_in_level <= s_tdata[2];
      poll.tick          <= s_tdata[3];
      poll.send_byte     <= s_tdata[11:4];
    end
  end

  // Edge/bit logic; state advances only when the poll is processed
  spibe_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (process),
    .item (poll),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.byte_done, out_res.separator, out_res.bit_value,
                     out_res.bit_valid, out_res.drive_level, out_res.drive_valid};

  a_process_fills: assert property (@(posedge clk) disable iff (rst)
    process |=> out_valid)
    else $error("processed poll did not reach result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> $stable(out_res))
    else $error("stalled result overwritten");

  a_poll_held: assert property (@(posedge clk) disable iff (rst)
    poll_valid && !process |=> poll_valid && $stable(poll))
    else $error("pending poll lost");

endmodule
